// ===== design/okv_pkg.sv =====
// ----------------------------------------------------------------------------
// okv_pkg: shared types and constants for the ordered key-value table
// Sizes, operation and status codes, and the structs passed between the
// sequencer, the entry store and the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package okv_pkg;

   // Table geometry
   localparam int CAPACITY = 16;
   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);

   // Field widths of the channels
   localparam int MODE_W  = 3;
   localparam int KEY_W   = 32;
   localparam int VAL_W   = 32;
   localparam int POS_W   = 4;
   localparam int STAT_W  = 3;
   localparam int ENTRY_W = 5;

   // Common width for comparing a position against the entry count
   localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

   typedef enum logic [MODE_W-1:0] {
      MODE_INSERT     = 3'd0,
      MODE_UPDATE     = 3'd1,
      MODE_UPSERT     = 3'd2,
      MODE_ERASE      = 3'd3,
      MODE_LOOKUP     = 3'd4,
      MODE_READ_INDEX = 3'd5
   } mode_type;

   typedef enum logic [STAT_W-1:0] {
      STAT_DONE    = 3'd0,
      STAT_ABSENT  = 3'd1,
      STAT_PRESENT = 3'd2,
      STAT_FULL    = 3'd3,
      STAT_RANGE   = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_SHIFT,
      ST_FETCH,
      ST_REPLY
   } state_type;

   // Access to the entry store: one read and one write port
   typedef struct packed {
      logic             rd_en;
      logic [IDX_W-1:0] rd_addr;
      logic             wr_en;
      logic [IDX_W-1:0] wr_addr;
      logic [KEY_W-1:0] wr_key;
      logic [VAL_W-1:0] wr_value;
   } store_req_type;

   // One finished result word
   typedef struct packed {
      status_type       status;
      logic [KEY_W-1:0] key;
      logic [VAL_W-1:0] value;
      logic [CNT_W-1:0] count;
   } result_type;

endpackage : okv_pkg

`default_nettype wire

// ===== design/okv_store.sv =====
// ----------------------------------------------------------------------------
// okv_store: entry store of the ordered key-value table
// Key and value memories sharing one address per port; synchronous write,
// read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module okv_store
   import okv_pkg::*;
(
   input  wire logic          clock,
   input  wire store_req_type store_req,
   output logic [KEY_W-1:0]   rd_key,
   output logic [VAL_W-1:0]   rd_value
);

   logic [KEY_W-1:0] key_mem [CAPACITY];
   logic [VAL_W-1:0] value_mem [CAPACITY];
   logic [KEY_W-1:0] rd_key_ff;
   logic [VAL_W-1:0] rd_value_ff;

   // write port
   always_ff @(posedge clock) begin
      if (store_req.wr_en) begin
         key_mem[store_req.wr_addr]   <= store_req.wr_key;
         value_mem[store_req.wr_addr] <= store_req.wr_value;
      end
   end

   // read port, registered data
   always_ff @(posedge clock) begin
      if (store_req.rd_en) begin
         rd_key_ff   <= key_mem[store_req.rd_addr];
         rd_value_ff <= value_mem[store_req.rd_addr];
      end
   end

   assign rd_key   = rd_key_ff;
   assign rd_value = rd_value_ff;

endmodule : okv_store

`default_nettype wire

// ===== design/okv_ctrl.sv =====
// ----------------------------------------------------------------------------
// okv_ctrl: operation sequencer of the ordered key-value table
// Walks the entry store for key search and gap-closing shift, keeps the
// entry count and builds one result word per operation.
// ----------------------------------------------------------------------------
`default_nettype none

module okv_ctrl
   import okv_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire logic [MODE_W-1:0]   req_mode,
   input  wire logic [KEY_W-1:0]    req_key_in,
   input  wire logic [VAL_W-1:0]    req_value_in,
   input  wire logic [POS_W-1:0]    req_position,
   output store_req_type            store_req,
   input  wire logic [KEY_W-1:0]    rd_key,
   input  wire logic [VAL_W-1:0]    rd_value,
   output logic                     res_valid,
   input  wire logic                res_ready,
   output result_type               res
);

   state_type        state_ff, state_in;
   mode_type         mode_ff, mode_in;
   logic [KEY_W-1:0] key_ff, key_in;
   logic [VAL_W-1:0] value_ff, value_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] rd_idx_ff, rd_idx_in;
   logic             chk_ff, chk_in;
   logic [IDX_W-1:0] chk_idx_ff, chk_idx_in;
   logic [IDX_W-1:0] wr_ptr_ff, wr_ptr_in;
   status_type       status_ff, status_in;
   logic [KEY_W-1:0] kout_ff, kout_in;
   logic [VAL_W-1:0] vout_ff, vout_in;

   logic             hit;
   logic             more;
   logic             full;
   logic             pos_ok;

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         chk_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         chk_ff   <= chk_in;
      end
   end

   // operands, walk pointers and result fields
   always_ff @(posedge clock) begin
      mode_ff    <= mode_in;
      key_ff     <= key_in;
      value_ff   <= value_in;
      rd_idx_ff  <= rd_idx_in;
      chk_idx_ff <= chk_idx_in;
      wr_ptr_ff  <= wr_ptr_in;
      status_ff  <= status_in;
      kout_ff    <= kout_in;
      vout_ff    <= vout_in;
   end

   // a stored key checked this cycle matches; more entries left to read
   assign hit    = chk_ff && (rd_key == key_ff);
   assign more   = rd_idx_ff < count_ff;
   assign full   = count_ff == CNT_W'(CAPACITY);
   assign pos_ok = CMP_W'(req_position) < CMP_W'(count_ff);

   // next state and outputs
   always_comb begin
      state_in   = state_ff;
      mode_in    = mode_ff;
      key_in     = key_ff;
      value_in   = value_ff;
      count_in   = count_ff;
      rd_idx_in  = rd_idx_ff;
      chk_in     = chk_ff;
      chk_idx_in = chk_idx_ff;
      wr_ptr_in  = wr_ptr_ff;
      status_in  = status_ff;
      kout_in    = kout_ff;
      vout_in    = vout_ff;
      store_req  = '0;
      req_ready  = 1'b0;
      res_valid  = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               mode_in   = mode_type'(req_mode);
               key_in    = req_key_in;
               value_in  = req_value_in;
               rd_idx_in = '0;
               chk_in    = 1'b0;
               status_in = STAT_DONE;
               kout_in   = '0;
               vout_in   = '0;
               case (mode_type'(req_mode)) inside
                  MODE_INSERT, MODE_UPDATE, MODE_UPSERT, MODE_ERASE, MODE_LOOKUP: begin
                     state_in = ST_SCAN;
                  end
                  MODE_READ_INDEX: begin
                     if (pos_ok) begin
                        store_req.rd_en   = 1'b1;
                        store_req.rd_addr = IDX_W'(req_position);
                        state_in          = ST_FETCH;
                     end else begin
                        status_in = STAT_RANGE;
                        state_in  = ST_REPLY;
                     end
                  end
                  default: begin
                     state_in = ST_REPLY;
                  end
               endcase
            end
         end

         ST_FETCH: begin
            kout_in  = rd_key;
            vout_in  = rd_value;
            state_in = ST_REPLY;
         end

         // pipelined search: read one slot, compare the one read last cycle
         ST_SCAN: begin
            if (hit) begin
               state_in = ST_REPLY;
               case (mode_ff)
                  MODE_INSERT: begin
                     status_in = STAT_PRESENT;
                  end
                  MODE_UPDATE, MODE_UPSERT: begin
                     store_req.wr_en    = 1'b1;
                     store_req.wr_addr  = chk_idx_ff;
                     store_req.wr_key   = key_ff;
                     store_req.wr_value = value_ff;
                  end
                  MODE_ERASE: begin
                     rd_idx_in = CNT_W'(chk_idx_ff) + CNT_W'(1);
                     wr_ptr_in = chk_idx_ff;
                     chk_in    = 1'b0;
                     state_in  = ST_SHIFT;
                  end
                  MODE_LOOKUP: begin
                     vout_in = rd_value;
                  end
                  default: begin
                     status_in = STAT_DONE;
                  end
               endcase
            end else if (more) begin
               store_req.rd_en   = 1'b1;
               store_req.rd_addr = rd_idx_ff[IDX_W-1:0];
               chk_in            = 1'b1;
               chk_idx_in        = rd_idx_ff[IDX_W-1:0];
               rd_idx_in         = rd_idx_ff + CNT_W'(1);
            end else begin
               // key absent
               state_in = ST_REPLY;
               case (mode_ff)
                  MODE_INSERT, MODE_UPSERT: begin
                     if (full) begin
                        status_in = STAT_FULL;
                     end else begin
                        store_req.wr_en    = 1'b1;
                        store_req.wr_addr  = count_ff[IDX_W-1:0];
                        store_req.wr_key   = key_ff;
                        store_req.wr_value = value_ff;
                        count_in           = count_ff + CNT_W'(1);
                     end
                  end
                  default: begin
                     status_in = STAT_ABSENT;
                  end
               endcase
            end
         end

         // erase: move each later entry down one slot
         ST_SHIFT: begin
            if (chk_ff) begin
               store_req.wr_en    = 1'b1;
               store_req.wr_addr  = wr_ptr_ff;
               store_req.wr_key   = rd_key;
               store_req.wr_value = rd_value;
               wr_ptr_in          = wr_ptr_ff + IDX_W'(1);
            end
            if (more) begin
               store_req.rd_en   = 1'b1;
               store_req.rd_addr = rd_idx_ff[IDX_W-1:0];
               chk_in            = 1'b1;
               rd_idx_in         = rd_idx_ff + CNT_W'(1);
            end else begin
               chk_in = 1'b0;
               if (!chk_ff) begin
                  count_in = count_ff - CNT_W'(1);
                  state_in = ST_REPLY;
               end
            end
         end

         ST_REPLY: begin
            res_valid = 1'b1;
            if (res_ready) begin
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign res.status = status_ff;
   assign res.key    = kout_ff;
   assign res.value  = vout_ff;
   assign res.count  = count_ff;

endmodule : okv_ctrl

`default_nettype wire

// ===== design/ordered_key_value_table.sv =====
// ----------------------------------------------------------------------------
// ordered_key_value_table: bounded key-value table kept in insertion order
// Up to CAPACITY keys with values; insert, update, insert-or-update, erase,
// lookup by key and read by insertion-order index, one result word each.
// ----------------------------------------------------------------------------
// Usage:
//   Request words enter on req_* (valid/ready), one result word leaves on
//   rsp_* (valid/ready) for every request, in request order.
//   Key operations search the entry memory from the oldest entry, one slot
//   per cycle, with the compare in the cycle after the read. Erase then
//   shifts the later entries down, one slot per cycle. Read by index reads
//   its slot directly; unused modes reply without touching the memory.
//   The entry memory has one read and one write port; one request is in
//   progress at a time.
//   Results pass through an output register, so the next request is taken
//   while a result waits; a stalled receiver only holds the sequencer once
//   the following result is also finished.
//   Reset empties the table (entry count zero); the memory contents are
//   not cleared, as only slots below the count are ever read.
// ----------------------------------------------------------------------------
`default_nettype none

module ordered_key_value_table
   import okv_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire logic [MODE_W-1:0]    req_mode,
   input  wire logic [KEY_W-1:0]     req_key_in,
   input  wire logic [VAL_W-1:0]     req_value_in,
   input  wire logic [POS_W-1:0]     req_position,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output logic [STAT_W-1:0]         rsp_status,
   output logic [KEY_W-1:0]          rsp_key_out,
   output logic [VAL_W-1:0]          rsp_value_out,
   output logic [ENTRY_W-1:0]        rsp_entry_count
);

   store_req_type    store_req;
   logic [KEY_W-1:0] rd_key;
   logic [VAL_W-1:0] rd_value;
   logic             res_valid;
   logic             res_ready;
   result_type       res;

   logic             rsp_valid_ff, rsp_valid_in;
   result_type       rsp_word_ff, rsp_word_in;

   okv_store u_store (
      .clock     (clock),
      .store_req (store_req),
      .rd_key    (rd_key),
      .rd_value  (rd_value)
   );

   okv_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_mode     (req_mode),
      .req_key_in   (req_key_in),
      .req_value_in (req_value_in),
      .req_position (req_position),
      .store_req    (store_req),
      .rd_key       (rd_key),
      .rd_value     (rd_value),
      .res_valid    (res_valid),
      .res_ready    (res_ready),
      .res          (res)
   );

   // output register
   assign res_ready = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_word_in  = rsp_word_ff;
      if (res_ready) begin
         rsp_valid_in = res_valid;
         if (res_valid) begin
            rsp_word_in = res;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_word_ff.status;
   assign rsp_key_out     = rsp_word_ff.key;
   assign rsp_value_out   = rsp_word_ff.value;
   assign rsp_entry_count = ENTRY_W'(rsp_word_ff.count);

   // checks
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while an operation was in progress");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_entry_count <= ENTRY_W'(CAPACITY))
      else $error("entry count above capacity");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STAT_FULL |-> rsp_entry_count == ENTRY_W'(CAPACITY))
      else $error("table full reported below capacity");

   a_range_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STAT_RANGE |-> rsp_key_out == '0 && rsp_value_out == '0)
      else $error("index out of range with nonzero data");

endmodule : ordered_key_value_table

`default_nettype wire

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the ordered key-value table
// Drives request words with random bursts and gaps, stalls the result side
// on changing patterns, and predicts every result word from a local copy of
// the table. Each result word is checked field by field, in order.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top
   import okv_pkg::*;
();

   // Codes outside the defined modes, handled as no-ops by the block
   localparam logic [MODE_W-1:0] MODE_SPARE_LO = 3'd6;
   localparam logic [MODE_W-1:0] MODE_SPARE_HI = 3'd7;

   localparam int RANDOM_OPS  = 1118;
   localparam int STUCK_LIMIT = 2000;
   localparam int TAIL_CYCLES = 40;
   localparam int POOL_SIZE   = 24;

   // One request word as queued for the driver
   typedef struct {
      logic [MODE_W-1:0] mode;
      logic [KEY_W-1:0]  key;
      logic [VAL_W-1:0]  value;
      logic [POS_W-1:0]  pos;
      bit                after_drain;
   } table_op_type;

   // One predicted result word
   typedef struct {
      status_type         status;
      logic [KEY_W-1:0]   key;
      logic [VAL_W-1:0]   value;
      logic [ENTRY_W-1:0] count;
   } table_reply_type;

   logic clock;
   logic reset = 1'b1;

   logic                 req_valid    = 1'b0;
   logic                 req_ready;
   logic [MODE_W-1:0]    req_mode     = '0;
   logic [KEY_W-1:0]     req_key_in   = '0;
   logic [VAL_W-1:0]     req_value_in = '0;
   logic [POS_W-1:0]     req_position = '0;
   logic                 rsp_valid;
   logic                 rsp_ready    = 1'b0;
   logic [STAT_W-1:0]    rsp_status;
   logic [KEY_W-1:0]     rsp_key_out;
   logic [VAL_W-1:0]     rsp_value_out;
   logic [ENTRY_W-1:0]   rsp_entry_count;

   logic req_fire = 1'b0;

   table_op_type    queued_ops[$];
   table_reply_type awaited_replies[$];
   int              mismatch_count = 0;

   // Local copy of the table
   logic [KEY_W-1:0] shadow_key [CAPACITY];
   logic [VAL_W-1:0] shadow_val [CAPACITY];
   int               shadow_count = 0;

   logic [KEY_W-1:0]  key_pool [POOL_SIZE];
   int                mode_cut [3][8];
   logic [MODE_W-1:0] mode_pick [8];

   ordered_key_value_table uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_mode        (req_mode),
      .req_key_in      (req_key_in),
      .req_value_in    (req_value_in),
      .req_position    (req_position),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_key_out     (rsp_key_out),
      .rsp_value_out   (rsp_value_out),
      .rsp_entry_count (rsp_entry_count)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Apply one operation to the local table and return the result word
   function automatic table_reply_type apply_table_op(table_op_type op);
      table_reply_type r;
      int slot;
      r.status = STAT_DONE;
      r.key    = '0;
      r.value  = '0;
      // linear search from the oldest entry
      slot = shadow_count;
      for (int i = shadow_count - 1; i >= 0; i--)
         if (shadow_key[i] == op.key) slot = i;
      case (op.mode)
         MODE_INSERT, MODE_UPSERT: begin
            if (slot < shadow_count) begin
               if (op.mode == MODE_INSERT) r.status = STAT_PRESENT;
               else shadow_val[slot] = op.value;
            end else if (shadow_count >= CAPACITY) begin
               r.status = STAT_FULL;
            end else begin
               shadow_key[shadow_count] = op.key;
               shadow_val[shadow_count] = op.value;
               shadow_count++;
            end
         end
         MODE_UPDATE: begin
            if (slot < shadow_count) shadow_val[slot] = op.value;
            else r.status = STAT_ABSENT;
         end
         MODE_ERASE: begin
            // close the gap so insertion order is kept
            if (slot < shadow_count) begin
               for (int i = slot; i + 1 < shadow_count; i++) begin
                  shadow_key[i] = shadow_key[i + 1];
                  shadow_val[i] = shadow_val[i + 1];
               end
               shadow_count--;
            end else begin
               r.status = STAT_ABSENT;
            end
         end
         MODE_LOOKUP: begin
            if (slot < shadow_count) r.value = shadow_val[slot];
            else r.status = STAT_ABSENT;
         end
         MODE_READ_INDEX: begin
            if (op.pos < shadow_count) begin
               r.key   = shadow_key[op.pos];
               r.value = shadow_val[op.pos];
            end else begin
               r.status = STAT_RANGE;
            end
         end
         default: ;
      endcase
      r.count = shadow_count[ENTRY_W-1:0];
      return r;
   endfunction

   function automatic void add_op(logic [MODE_W-1:0] mode, logic [KEY_W-1:0] key,
                                  logic [VAL_W-1:0] value, logic [POS_W-1:0] pos,
                                  bit after_drain);
      table_op_type op;
      op.mode        = mode;
      op.key         = key;
      op.value       = value;
      op.pos         = pos;
      op.after_drain = after_drain;
      queued_ops.push_back(op);
   endfunction

   // Request driver: bursts and gaps, optional hold until all results are back
   always @(negedge clock) begin : drive_req
      int           gap_left;
      int           burst_left;
      logic         load;
      table_op_type op;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_fire) begin
         load = 1'b0;
         if (gap_left > 0)
            gap_left--;
         else if (queued_ops.size() != 0 &&
                  (!queued_ops[0].after_drain || awaited_replies.size() == 0))
            load = 1'b1;
         if (load) begin
            op = queued_ops.pop_front();
            req_mode     <= op.mode;
            req_key_in   <= op.key;
            req_value_in <= op.value;
            req_position <= op.pos;
            req_valid    <= 1'b1;
            if (burst_left <= 1) begin
               burst_left = $urandom_range(1, 20);
               gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            end else begin
               burst_left--;
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Result receiver: stall style changes every so often
   always @(negedge clock) begin : drive_rsp_ready
      int style;
      int style_left;
      int tick;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (style_left == 0) begin
            style      = $urandom_range(0, 3);
            style_left = $urandom_range(32, 200);
         end
         style_left--;
         tick++;
         case (style)
            0:       rsp_ready <= 1'b1;
            1:       rsp_ready <= ($urandom_range(0, 3) != 0);
            2:       rsp_ready <= ($urandom_range(0, 3) == 0);
            default: rsp_ready <= (tick % 5 == 0);
         endcase
      end
   end

   // Monitor: predict on each accepted request, check each accepted result
   // (words printed as status/key/value/count)
   always @(posedge clock) begin : watch_ports
      table_op_type    seen;
      table_reply_type want;
      req_fire <= !reset && req_valid && req_ready;
      if (!reset) begin
         if (req_valid && req_ready) begin
            seen.mode        = req_mode;
            seen.key         = req_key_in;
            seen.value       = req_value_in;
            seen.pos         = req_position;
            seen.after_drain = 1'b0;
            awaited_replies.push_back(apply_table_op(seen));
         end
         if (rsp_valid && rsp_ready) begin
            if (awaited_replies.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("%0t: unexpected result %0d/%h/%h/%0d", $time,
                           rsp_status, rsp_key_out, rsp_value_out, rsp_entry_count);
            end else begin
               want = awaited_replies.pop_front();
               if (rsp_status !== want.status || rsp_key_out !== want.key ||
                   rsp_value_out !== want.value || rsp_entry_count !== want.count) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("%0t: exp %0d/%h/%h/%0d got %0d/%h/%h/%0d", $time,
                              want.status, want.key, want.value, want.count,
                              rsp_status, rsp_key_out, rsp_value_out, rsp_entry_count);
               end
            end
         end
      end
   end

   // Watchdog: too long without any word moving on either channel
   initial begin : watchdog
      int stuck;
      stuck = 0;
      while (stuck < STUCK_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) stuck = 0;
         else stuck++;
      end
      $display("DONE: errors detected");
      $finish;
   end

   // Stimulus and end of run
   initial begin : stimulus
      int          n_random;
      int          bias;
      int          chunk;
      int          r;
      int          k;
      bit          hold;
      logic [31:0] key;

      for (int i = 0; i < POOL_SIZE; i++) key_pool[i] = $urandom;
      mode_pick = '{MODE_INSERT, MODE_UPDATE, MODE_UPSERT, MODE_ERASE,
                    MODE_LOOKUP, MODE_READ_INDEX, MODE_SPARE_LO, MODE_SPARE_HI};
      // cumulative weights: fill-heavy, erase-heavy, balanced
      mode_cut = '{'{35, 43, 68, 75, 87, 97, 98, 100},
                   '{12, 20, 28, 68, 83, 97, 98, 100},
                   '{18, 30, 46, 64, 80, 96, 98, 100}};

      // empty table: index out of range and key absent cases
      add_op(MODE_READ_INDEX, $urandom, $urandom, '0, 1'b0);
      add_op(MODE_LOOKUP, '0, $urandom, POS_W'($urandom_range(0, 15)), 1'b0);
      add_op(MODE_UPDATE, '1, $urandom, POS_W'($urandom_range(0, 15)), 1'b0);
      add_op(MODE_ERASE, '0, $urandom, POS_W'($urandom_range(0, 15)), 1'b0);
      // fill to capacity, extreme keys and values first and last
      add_op(MODE_INSERT, '0, '0, POS_W'($urandom_range(0, 15)), 1'b0);
      for (int i = 0; i < 14; i++)
         add_op(MODE_UPSERT, key_pool[i], $urandom, POS_W'($urandom_range(0, 15)), 1'b0);
      add_op(MODE_INSERT, '1, '1, '1, 1'b0);
      // full table, then present key
      add_op(MODE_INSERT, key_pool[20], $urandom, POS_W'($urandom_range(0, 15)), 1'b0);
      add_op(MODE_UPSERT, key_pool[21], $urandom, POS_W'($urandom_range(0, 15)), 1'b0);
      add_op(MODE_INSERT, '0, $urandom, POS_W'($urandom_range(0, 15)), 1'b0);
      // erase from the middle after a full drain, then check the shift
      add_op(MODE_ERASE, key_pool[4], $urandom, POS_W'($urandom_range(0, 15)), 1'b1);
      add_op(MODE_READ_INDEX, $urandom, $urandom, 4'd5, 1'b0);
      add_op(MODE_READ_INDEX, $urandom, $urandom, 4'd15, 1'b0);
      add_op(MODE_READ_INDEX, $urandom, $urandom, 4'd14, 1'b0);
      add_op(MODE_UPSERT, '0, 32'hA5A5_5A5A, POS_W'($urandom_range(0, 15)), 1'b0);
      add_op(MODE_LOOKUP, '1, $urandom, POS_W'($urandom_range(0, 15)), 1'b0);
      add_op(MODE_ERASE, '0, $urandom, POS_W'($urandom_range(0, 15)), 1'b0);
      add_op(MODE_SPARE_LO, $urandom, $urandom, POS_W'($urandom_range(0, 15)), 1'b0);
      add_op(MODE_SPARE_HI, $urandom, $urandom, POS_W'($urandom_range(0, 15)), 1'b0);

      // random chunks, each with its own operation mix
      n_random = 0;
      while (n_random < RANDOM_OPS) begin
         bias  = $urandom_range(0, 2);
         chunk = $urandom_range(20, 80);
         if (chunk > RANDOM_OPS - n_random) chunk = RANDOM_OPS - n_random;
         hold  = (n_random == 0) || ($urandom_range(0, 3) == 0);
         for (int j = 0; j < chunk; j++) begin
            r = $urandom_range(0, 99);
            k = 0;
            while (r >= mode_cut[bias][k]) k++;
            key = ($urandom_range(0, 9) == 0) ? $urandom
                                              : key_pool[$urandom_range(0, POOL_SIZE - 1)];
            add_op(mode_pick[k], key, $urandom, POS_W'($urandom_range(0, 15)),
                   hold && (j == 0));
            n_random++;
         end
      end

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // all words sent, all results back, then a short tail
      while (queued_ops.size() != 0 || req_valid) @(posedge clock);
      while (awaited_replies.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && awaited_replies.size() == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule : tb_top

`default_nettype wire
